// ----- hw/rtl/smcsr_pkg.sv -----
// Shared types and codes for the CSR sparse matrix store.
package smcsr_pkg;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic CFG_ROW_COUNT = 1'b0;
	localparam logic CFG_COL_COUNT = 1'b1;

	// Controller commands to the datapath
	typedef struct packed {
		logic load_req;     // capture request fields
		logic clr_wr;       // clear row pointer at walk index, advance it
		logic ptr_init;     // walk index = row + 1
		logic ptr_rd_lo;    // read row_start[row]
		logic ptr_rd_hi;    // read row_start[row+1]
		logic first_ld;     // scan index = pointer read
		logic last_ld;      // row end = pointer read
		logic ptr_wr;       // write back adjusted pointer, advance walk index
		logic ptr_inc;      // direction of adjust
		logic ent_rd;       // read entry
		logic rd_next;      // read at scan index + 1
		logic rd_prev;      // read at scan index - 1
		logic ent_wr;       // write entry at scan index
		logic wr_mv;        // write data is the entry just read
		logic k_inc;
		logic k_dec;
		logic k_to_cnt;     // scan index = entry count
		logic cnt_inc;
		logic cnt_dec;
		logic res_load;     // capture result
		logic [1:0] res_status;
		logic res_hit;
	} smcsr_cmd_t;

	// Datapath status to the controller
	typedef struct packed {
		logic is_write;
		logic range_bad;
		logic scan_done;    // scan index reached row end or count
		logic col_match;    // entry just read has requested column
		logic val_zero;
		logic full;
		logic dn_done;      // nothing left above the scan index to move down
		logic up_done;      // scan index reached the insert position
		logic ptr_last;     // walk index at the last row pointer
	} smcsr_stat_t;

endpackage

// ----- hw/rtl/smcsr_if.sv -----
// Valid/ready channel interfaces for requests, results and configuration.
interface smcsr_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [5:0] row;
	logic [5:0] col;
	logic signed [31:0] value;
	modport source (output valid, req_type, row, col, value, input ready);
	modport sink (input valid, req_type, row, col, value, output ready);
endinterface

interface smcsr_rsp_if;
	logic valid;
	logic ready;
	logic signed [31:0] read_value;
	logic found;
	logic [1:0] status;
	modport source (output valid, read_value, found, status, input ready);
	modport sink (input valid, read_value, found, status, output ready);
endinterface

interface smcsr_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic [6:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/smcsr_datapath.sv -----
// Datapath: entry memories, row pointers, scan/shift counters and result register.
module smcsr_datapath #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	parameter int ENTRY_CAPACITY = 256,
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  smcsr_pkg::smcsr_cmd_t cmd,
	output smcsr_pkg::smcsr_stat_t stat,
	input  logic req_type,
	input  logic [5:0] req_row,
	input  logic [5:0] req_col,
	input  logic [31:0] req_value,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [6:0] cfg_data,
	output logic [31:0] rsp_value,
	output logic rsp_found,
	output logic [1:0] rsp_status
);
	localparam int AW = $clog2(ENTRY_CAPACITY);
	localparam int CW = $clog2(ENTRY_CAPACITY + 1);
	localparam int RW = $clog2(MAX_ROWS + 1);

	logic [6:0] row_count_q, col_count_q;
	logic req_type_q;
	logic [5:0] row_q, col_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [CW-1:0] last_q, k_q, cnt_q;
	logic [RW-1:0] rp_q;
	logic [VALUE_WIDTH-1:0] ev_mem [ENTRY_CAPACITY];
	logic [5:0] ec_mem [ENTRY_CAPACITY];
	logic [CW-1:0] rs_mem [MAX_ROWS+1];
	logic [CW-1:0] rs_rd_q;
	logic [VALUE_WIDTH-1:0] rd_val_q;
	logic [5:0] rd_col_q;
	logic [RW-1:0] rs_addr;
	logic [CW-1:0] ptr_next;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= 7'd64;
			col_count_q <= 7'd64;
		end else if (cfg_we) begin
			if (cfg_index == smcsr_pkg::CFG_ROW_COUNT) row_count_q <= cfg_data;
			else col_count_q <= cfg_data;
		end
	end

	// Request capture; value kept in VALUE_WIDTH bits
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_type_q <= req_type;
			row_q <= req_row;
			col_q <= req_col;
			val_q <= VALUE_WIDTH'($signed(req_value));
		end
	end

	// Row pointer walk index (also drives the clearing pass after reset)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rp_q <= '0;
		else if (cmd.ptr_init) rp_q <= RW'(row_q) + RW'(1);
		else if (cmd.clr_wr || cmd.ptr_wr) rp_q <= rp_q + RW'(1);
	end

	// Row pointer memory: one registered read and one write per cycle
	always_comb begin
		rs_addr = rp_q;
		if (cmd.ptr_rd_lo) rs_addr = RW'(row_q);
		else if (cmd.ptr_rd_hi) rs_addr = RW'(row_q) + RW'(1);
	end

	always_comb begin
		if (cmd.ptr_inc) ptr_next = rs_rd_q + CW'(1);
		else if (rs_rd_q != '0) ptr_next = rs_rd_q - CW'(1);
		else ptr_next = rs_rd_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr) rs_mem[rp_q] <= '0;
		else if (cmd.ptr_wr) rs_mem[rp_q] <= ptr_next;
		rs_rd_q <= rs_mem[rs_addr];
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (cmd.cnt_inc) cnt_q <= cnt_q + CW'(1);
		else if (cmd.cnt_dec) cnt_q <= cnt_q - CW'(1);
	end

	// Scan/shift index and row end
	always_ff @(posedge clk) begin
		if (cmd.first_ld) k_q <= rs_rd_q;
		else if (cmd.k_to_cnt) k_q <= cnt_q;
		else if (cmd.k_inc) k_q <= k_q + CW'(1);
		else if (cmd.k_dec) k_q <= k_q - CW'(1);
		if (cmd.last_ld) last_q <= rs_rd_q;
	end

	// Entry memories: one write and one registered read per cycle
	assign wr_addr = AW'(k_q);

	always_comb begin
		rd_addr = AW'(k_q);
		if (cmd.rd_next) rd_addr = AW'(k_q + CW'(1));
		else if (cmd.rd_prev) rd_addr = AW'(k_q - CW'(1));
	end

	always_ff @(posedge clk) begin
		if (cmd.ent_wr) begin
			ev_mem[wr_addr] <= cmd.wr_mv ? rd_val_q : val_q;
			ec_mem[wr_addr] <= cmd.wr_mv ? rd_col_q : col_q;
		end
		if (cmd.ent_rd) begin
			rd_val_q <= ev_mem[rd_addr];
			rd_col_q <= ec_mem[rd_addr];
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			rsp_status <= cmd.res_status;
			rsp_found <= cmd.res_hit;
			rsp_value <= cmd.res_hit ? 32'($signed(rd_val_q)) : '0;
		end
	end

	// Status to the controller
	always_comb begin
		stat.is_write = req_type_q == smcsr_pkg::REQ_WRITE;
		stat.range_bad = (7'(row_q) >= row_count_q) || (32'(row_q) >= MAX_ROWS) ||
			(7'(col_q) >= col_count_q) || (32'(col_q) >= MAX_COLS);
		stat.scan_done = (k_q >= last_q) || (k_q >= cnt_q);
		stat.col_match = rd_col_q == col_q;
		stat.val_zero = val_q == '0;
		stat.full = (32'(cnt_q) >= ENTRY_CAPACITY) || (last_q > cnt_q);
		stat.dn_done = (32'(k_q) + 32'd1) >= 32'(cnt_q);
		stat.up_done = k_q <= last_q;
		stat.ptr_last = 32'(rp_q) >= MAX_ROWS;
	end
endmodule

// ----- hw/rtl/smcsr_ctrl.sv -----
// Controller state machine: sequences the clearing pass, range check, scan, shift and pointer update.
module smcsr_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  smcsr_pkg::smcsr_stat_t stat,
	output smcsr_pkg::smcsr_cmd_t cmd
);
	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_CHK, S_PLO, S_PHI, S_PLD, S_RD, S_CMP,
		S_DNCHK, S_DNWR, S_UPCHK, S_UPWR, S_INS, S_PRD, S_PWR, S_OUT
	} state_t;

	state_t state_q;
	logic hit_q;

	assign in_ready = state_q == S_IDLE && !out_valid;

	// Commands for the current state
	always_comb begin
		cmd = '0;
		case (state_q)
			S_CLR: cmd.clr_wr = 1'b1;
			S_IDLE: cmd.load_req = in_valid && in_ready;
			S_CHK: begin
				cmd.ptr_init = 1'b1;
				if (stat.range_bad) begin
					cmd.res_load = 1'b1;
					cmd.res_status = smcsr_pkg::ST_RANGE;
				end
			end
			S_PLO: cmd.ptr_rd_lo = 1'b1;
			S_PHI: begin
				cmd.ptr_rd_hi = 1'b1;
				cmd.first_ld = 1'b1;
			end
			S_PLD: cmd.last_ld = 1'b1;
			S_RD: begin
				if (!stat.scan_done) cmd.ent_rd = 1'b1;
				else begin
					// miss: answer now, insert if a nonzero write fits
					cmd.res_load = 1'b1;
					cmd.res_status = smcsr_pkg::ST_OK;
					if (stat.is_write && !stat.val_zero) begin
						if (stat.full) cmd.res_status = smcsr_pkg::ST_FULL;
						else cmd.k_to_cnt = 1'b1;
					end
				end
			end
			S_CMP: begin
				if (stat.col_match) begin
					cmd.res_load = 1'b1;
					cmd.res_hit = 1'b1;
					cmd.res_status = smcsr_pkg::ST_OK;
					// overwrite in place
					if (stat.is_write && !stat.val_zero) cmd.ent_wr = 1'b1;
				end else cmd.k_inc = 1'b1;
			end
			S_DNCHK: begin
				if (!stat.dn_done) begin
					cmd.ent_rd = 1'b1;
					cmd.rd_next = 1'b1;
				end
			end
			S_DNWR: begin
				cmd.ent_wr = 1'b1;
				cmd.wr_mv = 1'b1;
				cmd.k_inc = 1'b1;
			end
			S_UPCHK: begin
				if (!stat.up_done) begin
					cmd.ent_rd = 1'b1;
					cmd.rd_prev = 1'b1;
				end
			end
			S_UPWR: begin
				cmd.ent_wr = 1'b1;
				cmd.wr_mv = 1'b1;
				cmd.k_dec = 1'b1;
			end
			S_INS: cmd.ent_wr = 1'b1;
			S_PWR: begin
				cmd.ptr_wr = 1'b1;
				cmd.ptr_inc = !hit_q;
				if (stat.ptr_last) begin
					cmd.cnt_inc = !hit_q;
					cmd.cnt_dec = hit_q;
				end
			end
			default: ;
		endcase
	end

	// State and result valid; shifts step through S_DNCHK/S_DNWR or S_UPCHK/S_UPWR, pointer updates through S_PRD/S_PWR
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			out_valid <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			if (state_q == S_OUT) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_CLR: if (stat.ptr_last) state_q <= S_IDLE;
				S_IDLE: begin
					if (in_valid && in_ready) begin
						state_q <= S_CHK;
						hit_q <= 1'b0;
					end
				end
				S_CHK: state_q <= stat.range_bad ? S_OUT : S_PLO;
				S_PLO: state_q <= S_PHI;
				S_PHI: state_q <= S_PLD;
				S_PLD: state_q <= S_RD;
				S_RD: begin
					if (!stat.scan_done) state_q <= S_CMP;
					else if (stat.is_write && !stat.val_zero && !stat.full)
						state_q <= S_UPCHK;
					else state_q <= S_OUT;
				end
				S_CMP: begin
					if (!stat.col_match) state_q <= S_RD;
					else begin
						hit_q <= 1'b1;
						state_q <= (stat.is_write && stat.val_zero) ? S_DNCHK : S_OUT;
					end
				end
				S_DNCHK: state_q <= stat.dn_done ? S_PRD : S_DNWR;
				S_DNWR: state_q <= S_DNCHK;
				S_UPCHK: state_q <= stat.up_done ? S_INS : S_UPWR;
				S_UPWR: state_q <= S_UPCHK;
				S_INS: state_q <= S_PRD;
				S_PRD: state_q <= S_PWR;
				S_PWR: state_q <= stat.ptr_last ? S_OUT : S_PRD;
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) in_ready |-> state_q == S_IDLE)
		else $error("ready outside idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |=> out_valid) else $error("result lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_IDLE) else $error("result while busy");
endmodule

// ----- hw/rtl/sparse_matrix_csr_store.sv -----
// Top level of the CSR sparse matrix store.
//  channel  dir  fields
//  req      in   req_type row col value
//  rsp      out  read_value found status
//  cfg      in   index data
// One request at a time. A range error is answered from the check state; a miss
// reads the two row pointers and scans the row. An insert or delete also moves
// the entries above the insert or delete position, one entry per step, then
// adjusts every row pointer above the row, one pointer per step.
// After reset a clearing pass zeroes all MAX_ROWS+1 row pointers.
// A held result blocks the next request until taken.
module sparse_matrix_csr_store #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	parameter int ENTRY_CAPACITY = 256,
	parameter int VALUE_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	smcsr_req_if.sink req,
	smcsr_rsp_if.source rsp,
	smcsr_cfg_if.sink cfg
);
	smcsr_pkg::smcsr_cmd_t cmd;
	smcsr_pkg::smcsr_stat_t stat;

	assign cfg.ready = 1'b1;

	smcsr_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.stat, .cmd
	);

	smcsr_datapath #(
		.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS),
		.ENTRY_CAPACITY(ENTRY_CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk, .arst_n, .cmd, .stat,
		.req_type(req.req_type), .req_row(req.row), .req_col(req.col),
		.req_value(req.value),
		.cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
		.rsp_value(rsp.read_value), .rsp_found(rsp.found), .rsp_status(rsp.status)
	);
endmodule

// ----- verif/tb_sparse_matrix_csr_store.sv -----
// Testbench for the CSR sparse matrix store: directed table plus random requests.
module tb_sparse_matrix_csr_store;

	localparam int NROWS = 64;
	localparam int NCOLS = 64;
	localparam int CAP = 256;
	localparam int CYCLE_LIMIT = 8000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	smcsr_req_if req ();
	smcsr_rsp_if rsp ();
	smcsr_cfg_if cfg ();

	sparse_matrix_csr_store DUT (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	typedef struct {
		logic [31:0] read_value;
		logic found;
		logic [1:0] status;
	} csr_result_t;

	typedef struct {
		logic kind;
		logic [5:0] r;
		logic [5:0] c;
		logic [31:0] v;
		logic typed;       // expected result given in the row
		logic [31:0] exp_val;
		logic exp_found;
		logic [1:0] exp_status;
	} stim_row_t;

	// Shadow matrix state
	logic [31:0] shadow_val [CAP];
	logic [5:0] shadow_col [CAP];
	int unsigned shadow_start [NROWS + 1];
	int unsigned shadow_count;
	int unsigned rows_used;
	int unsigned cols_used;

	csr_result_t pending_results [$];
	csr_result_t no_res;
	int err_count = 0;
	int unsigned cycles = 0;
	bit long_hold = 1'b0;
	bit stim_done = 1'b0;

	// Computes the result of one request and updates the shadow matrix.
	function automatic csr_result_t csr_apply(logic kind, logic [5:0] r, logic [5:0] c,
			logic [31:0] v);
		csr_result_t res;
		int unsigned first, last, pos, k;
		bit hit;
		res = '{32'd0, 1'b0, smcsr_pkg::ST_OK};
		hit = 1'b0;
		pos = 0;
		if (r >= rows_used || r >= NROWS || c >= cols_used || c >= NCOLS) begin
			res.status = smcsr_pkg::ST_RANGE;
			return res;
		end
		first = shadow_start[r];
		last = shadow_start[r + 1];
		for (k = first; k < last && k < shadow_count; k++)
			if (!hit && shadow_col[k] == c) begin
				hit = 1'b1;
				pos = k;
			end
		if (hit) begin
			res.read_value = shadow_val[pos];
			res.found = 1'b1;
		end
		if (kind == smcsr_pkg::REQ_READ)
			return res;
		if (hit) begin
			if (v == 0) begin
				for (k = pos; k + 1 < shadow_count; k++) begin
					shadow_val[k] = shadow_val[k + 1];
					shadow_col[k] = shadow_col[k + 1];
				end
				for (k = r + 1; k <= NROWS; k++)
					if (shadow_start[k] > 0)
						shadow_start[k]--;
				shadow_count--;
			end else
				shadow_val[pos] = v;
		end else if (v != 0) begin
			if (shadow_count >= CAP || last > shadow_count) begin
				res.status = smcsr_pkg::ST_FULL;
				return res;
			end
			for (k = shadow_count; k > last; k--) begin
				shadow_val[k] = shadow_val[k - 1];
				shadow_col[k] = shadow_col[k - 1];
			end
			shadow_val[last] = v;
			shadow_col[last] = c;
			for (k = r + 1; k <= NROWS; k++)
				shadow_start[k]++;
			shadow_count++;
		end
		return res;
	endfunction

	// Gap length: mostly none or short, a few long
	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 50)
			return 0;
		if (p < 93)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Sends one request and books its expected result; valid stays up for the next one
	task automatic send_req(logic kind, logic [5:0] r, logic [5:0] c, logic [31:0] v,
			bit typed, csr_result_t typed_res);
		csr_result_t res;
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.row <= r;
		req.col <= c;
		req.value <= v;
		do @(posedge clk); while (!req.ready);
		res = csr_apply(kind, r, c, v);
		if (typed && (res.read_value !== typed_res.read_value ||
				res.found !== typed_res.found || res.status !== typed_res.status)) begin
			$error("table row disagrees with shadow model r=%0d c=%0d", r, c);
			err_count++;
		end
		pending_results.push_back(typed ? typed_res : res);
	endtask

	task automatic idle_cycles(int n);
		if (n > 0)
			req.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Stops offering requests and waits for every expected result
	task automatic drain();
		req.valid <= 1'b0;
		wait (pending_results.size() == 0);
	endtask

	// Configuration writes only once everything has drained
	task automatic write_reg(logic idx, logic [6:0] data);
		drain();
		idle_cycles(600);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == smcsr_pkg::CFG_ROW_COUNT)
			rows_used = data;
		else
			cols_used = data;
	endtask

	// Result checker
	always @(posedge clk) begin
		csr_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result");
				err_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp.read_value !== want.read_value) begin
					$error("read_value: expected %0d actual %0d",
						$signed(want.read_value), $signed(rsp.read_value));
					err_count++;
				end
				if (rsp.found !== want.found) begin
					$error("found: expected %0d actual %0d", want.found, rsp.found);
					err_count++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0d actual %0d", want.status, rsp.status);
					err_count++;
				end
			end
		end
	end

	// Result side stall
	initial begin
		int g;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				rsp.ready <= 1'b0;
				repeat (3000) @(posedge clk);
				long_hold = 1'b0;
			end else begin
				g = (stim_done || $urandom_range(3) == 0) ? 0 : gap_len();
				if (g > 0) begin
					rsp.ready <= 1'b0;
					repeat (g - 1) @(posedge clk);
				end else
					rsp.ready <= 1'b1;
			end
		end
	end

	// Timeout
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	stim_row_t stim_table [$];

	function automatic stim_row_t row_of(logic kind, int r, int c, logic [31:0] v);
		stim_row_t s;
		s = '{kind, r[5:0], c[5:0], v, 1'b0, 32'd0, 1'b0, smcsr_pkg::ST_OK};
		return s;
	endfunction

	function automatic stim_row_t typed_row(logic kind, int r, int c, logic [31:0] v,
			logic [31:0] ev, logic ef, logic [1:0] es);
		stim_row_t s;
		s = '{kind, r[5:0], c[5:0], v, 1'b1, ev, ef, es};
		return s;
	endfunction

	task automatic run_table();
		csr_result_t t;
		foreach (stim_table[i]) begin
			t = '{stim_table[i].exp_val, stim_table[i].exp_found, stim_table[i].exp_status};
			idle_cycles(gap_len());
			send_req(stim_table[i].kind, stim_table[i].r, stim_table[i].c, stim_table[i].v,
				stim_table[i].typed, t);
		end
		stim_table.delete();
	endtask

	// Random value with frequent extremes
	function automatic logic [31:0] rand_value();
		int p;
		p = $urandom_range(9);
		if (p == 0) return 32'h8000_0000;
		if (p == 1) return 32'h7FFF_FFFF;
		if (p == 2) return 32'hFFFF_FFFF;
		if (p == 3) return 32'd0;
		return $urandom();
	endfunction

	// Random phase: focused on a small window of rows/cols so hits are common
	task automatic random_phase(int n, int rspan, int cspan, int wr_pct);
		logic kind;
		int r, c;
		logic [31:0] v;
		for (int i = 0; i < n; i++) begin
			kind = ($urandom_range(99) < wr_pct) ? smcsr_pkg::REQ_WRITE : smcsr_pkg::REQ_READ;
			if ($urandom_range(19) == 0) begin
				r = $urandom_range(63);
				c = $urandom_range(63);
			end else begin
				r = $urandom_range(rspan - 1);
				c = $urandom_range(cspan - 1);
			end
			v = ($urandom_range(4) == 0) ? 32'd0 : rand_value();
			if (i % 8 == 7)
				idle_cycles(gap_len());
			send_req(kind, r[5:0], c[5:0], v, 1'b0, no_res);
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.req_type = smcsr_pkg::REQ_READ;
		req.row = '0;
		req.col = '0;
		req.value = '0;
		cfg.valid = 1'b0;
		cfg.index = smcsr_pkg::CFG_ROW_COUNT;
		cfg.data = '0;
		no_res = '{32'd0, 1'b0, smcsr_pkg::ST_OK};
		shadow_count = 0;
		foreach (shadow_start[i])
			shadow_start[i] = 0;
		rows_used = 64;
		cols_used = 64;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part
		stim_table.push_back(typed_row(smcsr_pkg::REQ_READ, 0, 0, 0, 0, 1'b0,
			smcsr_pkg::ST_OK));
		stim_table.push_back(typed_row(smcsr_pkg::REQ_READ, 63, 63, 0, 0, 1'b0,
			smcsr_pkg::ST_OK));
		stim_table.push_back(typed_row(smcsr_pkg::REQ_WRITE, 0, 0, 32'h8000_0000, 0, 1'b0,
			smcsr_pkg::ST_OK));
		stim_table.push_back(typed_row(smcsr_pkg::REQ_READ, 0, 0, 0, 32'h8000_0000, 1'b1,
			smcsr_pkg::ST_OK));
		stim_table.push_back(typed_row(smcsr_pkg::REQ_WRITE, 63, 63, 32'h7FFF_FFFF, 0, 1'b0,
			smcsr_pkg::ST_OK));
		stim_table.push_back(row_of(smcsr_pkg::REQ_WRITE, 0, 5, 32'hFFFF_FFFF));
		stim_table.push_back(row_of(smcsr_pkg::REQ_WRITE, 0, 0, 32'd7));
		stim_table.push_back(typed_row(smcsr_pkg::REQ_WRITE, 10, 10, 0, 0, 1'b0,
			smcsr_pkg::ST_OK));
		stim_table.push_back(row_of(smcsr_pkg::REQ_WRITE, 0, 0, 32'd0));
		stim_table.push_back(row_of(smcsr_pkg::REQ_READ, 0, 5, 0));
		stim_table.push_back(row_of(smcsr_pkg::REQ_WRITE, 32, 42, 32'h5555_AAAA));
		stim_table.push_back(row_of(smcsr_pkg::REQ_WRITE, 31, 21, 32'hAAAA_5555));
		stim_table.push_back(row_of(smcsr_pkg::REQ_READ, 63, 63, 0));
		stim_table.push_back(row_of(smcsr_pkg::REQ_WRITE, 63, 63, 32'd0));
		run_table();

		// Small matrix: range errors at the register extremes
		write_reg(smcsr_pkg::CFG_ROW_COUNT, 7'd1);
		write_reg(smcsr_pkg::CFG_COL_COUNT, 7'd1);
		stim_table.push_back(typed_row(smcsr_pkg::REQ_READ, 1, 0, 0, 0, 1'b0,
			smcsr_pkg::ST_RANGE));
		stim_table.push_back(typed_row(smcsr_pkg::REQ_WRITE, 0, 1, 32'd9, 0, 1'b0,
			smcsr_pkg::ST_RANGE));
		stim_table.push_back(typed_row(smcsr_pkg::REQ_WRITE, 63, 63, 32'd9, 0, 1'b0,
			smcsr_pkg::ST_RANGE));
		stim_table.push_back(row_of(smcsr_pkg::REQ_WRITE, 0, 0, 32'd3));
		run_table();
		random_phase(60, 2, 2, 60);

		write_reg(smcsr_pkg::CFG_ROW_COUNT, 7'd0);
		stim_table.push_back(typed_row(smcsr_pkg::REQ_READ, 0, 0, 0, 0, 1'b0,
			smcsr_pkg::ST_RANGE));
		run_table();
		write_reg(smcsr_pkg::CFG_ROW_COUNT, 7'd64);
		write_reg(smcsr_pkg::CFG_COL_COUNT, 7'd8);
		random_phase(300, 8, 8, 55);

		// Fill the store toward capacity, then hit the full case
		write_reg(smcsr_pkg::CFG_COL_COUNT, 7'd64);
		random_phase(450, 64, 64, 95);
		for (int r = 0; r < 64 && shadow_count < CAP; r++)
			for (int c = 0; c < 8 && shadow_count < CAP; c++)
				send_req(smcsr_pkg::REQ_WRITE, r[5:0], c[5:0], 32'(c + 1), 1'b0, no_res);
		send_req(smcsr_pkg::REQ_WRITE, 6'd5, 6'd60, 32'd77, 1'b0, no_res);
		send_req(smcsr_pkg::REQ_WRITE, 6'd5, 6'd0, 32'd0, 1'b0, no_res);

		// Backpressure: long result stall while requests keep coming
		long_hold = 1'b1;
		random_phase(40, 64, 64, 50);
		drain();
		idle_cycles(50);

		random_phase(400, 16, 16, 50);
		write_reg(smcsr_pkg::CFG_ROW_COUNT, 7'd33);
		write_reg(smcsr_pkg::CFG_COL_COUNT, 7'd17);
		random_phase(300, 40, 20, 50);
		write_reg(smcsr_pkg::CFG_ROW_COUNT, 7'd64);
		write_reg(smcsr_pkg::CFG_COL_COUNT, 7'd64);
		random_phase(200, 64, 64, 50);

		stim_done = 1'b1;
		drain();
		idle_cycles(600);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
